FILE: rtl/bmpl_pkg.sv
// ============================================================================
// bmpl_pkg
// Shared types and constants of the bump-mapped light spot renderer.
// ============================================================================
`default_nettype none

package bmpl_pkg;

  // Default sizes and the fixed row limit
  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int MAX_SPOT_SIZE_DEF = 256;
  localparam int MAX_HEIGHT        = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_LIGHT_X      = 3'd2,
    CFG_LIGHT_Y      = 3'd3,
    CFG_SPOT_SIZE    = 3'd4
  } cfg_reg_t;

  // Register widths and reset values
  localparam int FW_W = 11;
  localparam int FH_W = 11;
  localparam int LX_W = 10;
  localparam int LY_W = 10;
  localparam int SS_W = 9;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 11'd240;
  localparam logic [LX_W-1:0] LIGHT_X_RST      = 10'd160;
  localparam logic [LY_W-1:0] LIGHT_Y_RST      = 10'd120;
  localparam logic [SS_W-1:0] SPOT_SIZE_RST    = 9'd256;

  // Row counter holds up to MAX_HEIGHT + 1
  localparam int RW = 11;

  // Item kinds (tuser bit 0)
  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_HEIGHT      = 1'b1;

  // One line store entry: both buffered rows at one bordered column
  typedef struct packed {
    logic [7:0] upper;
    logic [7:0] middle;
  } line_word_t;

  // One lit pixel
  typedef struct packed {
    logic       end_of_frame;
    logic [7:0] intensity;
    logic [9:0] pixel_y;
    logic [9:0] pixel_x;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/bmpl_line.sv
// ============================================================================
// bmpl_line
// Two-row line store: one write port, two registered read ports, with
// forwarding of the write that lands on the same edge as a read.
// ============================================================================
`default_nettype none

module bmpl_line #(
  parameter int MAX_WIDTH = bmpl_pkg::MAX_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire  [$clog2(MAX_WIDTH+2)-1:0]   rd_addr0,
  input  wire  [$clog2(MAX_WIDTH+2)-1:0]   rd_addr1,
  input  wire                              wr_en,
  input  wire  [$clog2(MAX_WIDTH+2)-1:0]   wr_addr,
  input  bmpl_pkg::line_word_t             wr_data,
  output bmpl_pkg::line_word_t             rd_data0,
  output logic [7:0]                       rd_mid1
);

  localparam int LINE_DEPTH = MAX_WIDTH + 2;
  localparam int AW         = $clog2(LINE_DEPTH);

  bmpl_pkg::line_word_t mem [LINE_DEPTH];

  bmpl_pkg::line_word_t rd0;
  logic [7:0]           rd1;
  logic [AW-1:0]        addr0;
  logic [AW-1:0]        addr1;

  // last write, for a read issued on the same edge
  logic                 fwd_valid;
  logic [AW-1:0]        fwd_addr;
  bmpl_pkg::line_word_t fwd_data;

  // storage and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd0   <= mem[rd_addr0];
      rd1   <= mem[rd_addr1].middle;
      addr0 <= rd_addr0;
      addr1 <= rd_addr1;
    end
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  // bypass
  always_comb begin
    rd_data0 = (fwd_valid && addr0 == fwd_addr) ? fwd_data : rd0;
    rd_mid1  = (fwd_valid && addr1 == fwd_addr) ? fwd_data.middle : rd1;
  end

endmodule

`default_nettype wire

FILE: rtl/bmpl_spot.sv
// ============================================================================
// bmpl_spot
// Light spot table: single-port memory with a registered read.
// ============================================================================
`default_nettype none

module bmpl_spot #(
  parameter int MAX_SPOT_SIZE = bmpl_pkg::MAX_SPOT_SIZE_DEF
) (
  input  wire                                              clk,
  input  wire                                              we,
  input  wire                                              re,
  input  wire  [$clog2(MAX_SPOT_SIZE*MAX_SPOT_SIZE)-1:0]   addr,
  input  wire  [7:0]                                       wdata,
  output logic [7:0]                                       rdata
);

  localparam int DEPTH = MAX_SPOT_SIZE * MAX_SPOT_SIZE;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bmpl_skid.sv
// ============================================================================
// bmpl_skid
// Output register with one skid entry; upstream ready is a flop.
// ============================================================================
`default_nettype none

module bmpl_skid (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  bmpl_pkg::result_t push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  wire               out_ready,
  output bmpl_pkg::result_t out_data
);

  logic              skid_valid;
  bmpl_pkg::result_t skid_data;
  logic              slot_free;

  assign in_ready  = !skid_valid;
  assign slot_free = !out_valid || out_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bump_map_phong_lighting.sv
// ============================================================================
// bump_map_phong_lighting
// Bump-mapped light spot renderer over a bordered height map stream.
// ============================================================================
// Usage:
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the interior
//   frame size, light position and spot size; write them while no item is in
//   flight. The input stream carries two kinds of item, chosen by tuser[0]:
//   a spot table write (index, value) or one height sample of the bordered
//   raster, (width+2) by (height+2), with tuser[1] on the first sample of a
//   frame. An interior pixel comes out when the sample below it arrives;
//   tlast marks the last pixel of a frame.
//   A result passes the pipeline stages and the output register. One item
//   per cycle while s_axis_tready is high, held by the line store's two
//   read ports plus one write port and the single-port spot table.
//   Reset clears the raster position, the held samples and the registers
//   to their defaults; the memories keep their contents and need no sweep.
//   If the receiver stalls, one more result fits in the skid entry, then
//   s_axis_tready drops and the whole pipeline holds until space returns.
// ============================================================================
`default_nettype none

module bump_map_phong_lighting #(
  parameter int MAX_WIDTH     = bmpl_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SPOT_SIZE = bmpl_pkg::MAX_SPOT_SIZE_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [bmpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [bmpl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: table_index[15:0], table_value[23:16], height_value[31:24]
  input  wire  [31:0]                       s_axis_tdata,
  // tuser: operation[0], start_of_frame[1]
  input  wire  [1:0]                        s_axis_tuser,
  // result items
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata: pixel_x[9:0], pixel_y[19:10], intensity[27:20], zero pad[31:28]
  output logic [31:0]                       m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int LINE_DEPTH  = MAX_WIDTH + 2;
  localparam int CW          = $clog2(LINE_DEPTH);
  localparam int RW          = bmpl_pkg::RW;
  localparam int QW          = ((CW > 11) ? CW : 11) + 3;
  localparam int SB          = $clog2(MAX_SPOT_SIZE);
  localparam int SZW         = $clog2(MAX_SPOT_SIZE + 1);
  localparam int TABLE_DEPTH = MAX_SPOT_SIZE * MAX_SPOT_SIZE;
  localparam int TW          = $clog2(TABLE_DEPTH);

  // ---------------- configuration registers ----------------
  logic [bmpl_pkg::FW_W-1:0] frame_width;
  logic [bmpl_pkg::FH_W-1:0] frame_height;
  logic [bmpl_pkg::LX_W-1:0] light_x;
  logic [bmpl_pkg::LY_W-1:0] light_y;
  logic [bmpl_pkg::SS_W-1:0] spot_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bmpl_pkg::FRAME_WIDTH_RST;
      frame_height <= bmpl_pkg::FRAME_HEIGHT_RST;
      light_x      <= bmpl_pkg::LIGHT_X_RST;
      light_y      <= bmpl_pkg::LIGHT_Y_RST;
      spot_size    <= bmpl_pkg::SPOT_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmpl_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[bmpl_pkg::FW_W-1:0];
        bmpl_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[bmpl_pkg::FH_W-1:0];
        bmpl_pkg::CFG_LIGHT_X:      light_x      <= cfg_data[bmpl_pkg::LX_W-1:0];
        bmpl_pkg::CFG_LIGHT_Y:      light_y      <= cfg_data[bmpl_pkg::LY_W-1:0];
        bmpl_pkg::CFG_SPOT_SIZE:    spot_size    <= cfg_data[bmpl_pkg::SS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [CW-1:0]  w_lim;
  logic [RW-1:0]  h_lim;
  logic [SZW-1:0] res_lim;
  logic [SZW-2:0] half;

  always_comb begin
    if (frame_width == '0) begin
      w_lim = CW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_lim = CW'(MAX_WIDTH);
    end else begin
      w_lim = CW'(frame_width);
    end
    if (frame_height == '0) begin
      h_lim = RW'(1);
    end else if (32'(frame_height) > bmpl_pkg::MAX_HEIGHT) begin
      h_lim = RW'(bmpl_pkg::MAX_HEIGHT);
    end else begin
      h_lim = RW'(frame_height);
    end
    if (32'(spot_size) < 2) begin
      res_lim = SZW'(2);
    end else if (32'(spot_size) > MAX_SPOT_SIZE) begin
      res_lim = SZW'(MAX_SPOT_SIZE);
    end else begin
      res_lim = SZW'(spot_size);
    end
    half = res_lim[SZW-1:1];
  end

  // ---------------- pipeline advance ----------------
  logic adv;
  logic in_acc;

  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------- stage 0: raster position ----------------
  logic          op_in;
  logic          sof_in;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic [CW:0]   c_inc;
  logic [CW-1:0] rd_addr1;
  logic          emit0;
  logic          eof0;
  logic          col_wrap;
  logic          row_wrap;

  assign op_in  = s_axis_tuser[0];
  assign sof_in = s_axis_tuser[1];

  always_comb begin
    c_cur    = sof_in ? '0 : col;
    r_cur    = sof_in ? '0 : row;
    c_inc    = (CW+1)'(c_cur) + (CW+1)'(1);
    rd_addr1 = (c_inc == (CW+1)'(LINE_DEPTH)) ? '0 : c_inc[CW-1:0];
    emit0    = (r_cur >= RW'(2)) && (r_cur <= h_lim + RW'(1)) &&
               (c_cur >= CW'(1)) && (c_cur <= w_lim);
    eof0     = (c_cur == w_lim) && (r_cur == h_lim + RW'(1));
    col_wrap = (CW+1)'(c_cur) >= (CW+1)'(w_lim) + (CW+1)'(1);
    row_wrap = r_cur >= h_lim + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_acc && op_in == bmpl_pkg::OP_HEIGHT) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : r_cur + RW'(1);
      end else begin
        col <= c_inc[CW-1:0];
        row <= r_cur;
      end
    end
  end

  // ---------------- stage 1: line store data ----------------
  logic          s1_valid;
  logic          s1_op;
  logic          s1_emit;
  logic          s1_eof;
  logic [CW-1:0] s1_c;
  logic [RW-1:0] s1_r;
  logic [7:0]    s1_sample;
  logic [15:0]   s1_idx;
  logic [7:0]    s1_val;
  logic [7:0]    centre;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op     <= op_in;
      s1_emit   <= emit0;
      s1_eof    <= eof0;
      s1_c      <= c_cur;
      s1_r      <= r_cur;
      s1_sample <= s_axis_tdata[31:24];
      s1_idx    <= s_axis_tdata[15:0];
      s1_val    <= s_axis_tdata[23:16];
    end
  end

  logic                 line_we;
  bmpl_pkg::line_word_t line_wdata;
  bmpl_pkg::line_word_t ent_c;
  logic [7:0]           right;

  assign line_we = adv && s1_valid && s1_op == bmpl_pkg::OP_HEIGHT;

  always_comb begin
    line_wdata.upper  = ent_c.middle;
    line_wdata.middle = s1_sample;
  end

  bmpl_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .rd_addr0 (c_cur),
    .rd_addr1 (rd_addr1),
    .wr_en    (line_we),
    .wr_addr  (s1_c),
    .wr_data  (line_wdata),
    .rd_data0 (ent_c),
    .rd_mid1  (right)
  );

  // held sample of the row above; the old one is the left neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      centre <= '0;
    end else if (line_we) begin
      centre <= ent_c.middle;
    end
  end

  // displaced light offsets
  logic [CW-1:0] s1_i;
  logic [RW-1:0] s1_j;
  logic [QW-1:0] xq;
  logic [QW-1:0] yq;
  logic          inr;

  always_comb begin
    s1_i = s1_c - CW'(1);
    s1_j = s1_r - RW'(2);
    xq   = QW'(centre) - QW'(right) + QW'(s1_i) - QW'(light_x) + QW'(half);
    yq   = QW'(ent_c.upper) - QW'(s1_sample) + QW'(s1_j) - QW'(light_y) + QW'(half);
    inr  = !xq[QW-1] && !yq[QW-1] && (xq < QW'(res_lim)) && (yq < QW'(res_lim));
  end

  // ---------------- stage 2: row offset product ----------------
  logic          s2_valid;
  logic          s2_op;
  logic          s2_emit;
  logic          s2_eof;
  logic          s2_inr;
  logic [9:0]    s2_x;
  logic [9:0]    s2_y;
  logic [SB-1:0] s2_xq;
  logic [SB-1:0] s2_yq;
  logic [15:0]   s2_idx;
  logic [7:0]    s2_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op   <= s1_op;
      s2_emit <= s1_emit;
      s2_eof  <= s1_eof;
      s2_inr  <= inr;
      s2_x    <= s1_i[9:0];
      s2_y    <= s1_j[9:0];
      s2_xq   <= xq[SB-1:0];
      s2_yq   <= yq[SB-1:0];
      s2_idx  <= s1_idx;
      s2_val  <= s1_val;
    end
  end

  // ---------------- stage 3: table access ----------------
  logic          s3_valid;
  logic          s3_op;
  logic          s3_emit;
  logic          s3_eof;
  logic          s3_inr;
  logic [9:0]    s3_x;
  logic [9:0]    s3_y;
  logic [TW-1:0] s3_prod;
  logic [SB-1:0] s3_yq;
  logic [15:0]   s3_idx;
  logic [7:0]    s3_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op   <= s2_op;
      s3_emit <= s2_emit;
      s3_eof  <= s2_eof;
      s3_inr  <= s2_inr;
      s3_x    <= s2_x;
      s3_y    <= s2_y;
      s3_prod <= TW'(s2_xq) * TW'(res_lim);
      s3_yq   <= s2_yq;
      s3_idx  <= s2_idx;
      s3_val  <= s2_val;
    end
  end

  logic          tbl_we;
  logic          tbl_re;
  logic [TW-1:0] tbl_addr;
  logic [7:0]    tbl_rdata;

  always_comb begin
    tbl_we   = adv && s3_valid && s3_op == bmpl_pkg::OP_TABLE_WRITE &&
               (32'(s3_idx) < TABLE_DEPTH);
    tbl_re   = adv && s3_valid && s3_op == bmpl_pkg::OP_HEIGHT && s3_emit && s3_inr;
    tbl_addr = (s3_op == bmpl_pkg::OP_TABLE_WRITE) ? TW'(s3_idx)
                                                   : s3_prod + TW'(s3_yq);
  end

  bmpl_spot #(
    .MAX_SPOT_SIZE (MAX_SPOT_SIZE)
  ) u_spot (
    .clk   (clk),
    .we    (tbl_we),
    .re    (tbl_re),
    .addr  (tbl_addr),
    .wdata (s3_val),
    .rdata (tbl_rdata)
  );

  // ---------------- stage 4: result ----------------
  logic       s4_push;
  logic       s4_eof;
  logic       s4_inr;
  logic [9:0] s4_x;
  logic [9:0] s4_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_push <= 1'b0;
    end else if (adv) begin
      s4_push <= s3_valid && s3_op == bmpl_pkg::OP_HEIGHT && s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_eof <= s3_eof;
      s4_inr <= s3_inr;
      s4_x   <= s3_x;
      s4_y   <= s3_y;
    end
  end

  bmpl_pkg::result_t res_in;
  bmpl_pkg::result_t res_out;

  always_comb begin
    res_in.pixel_x      = s4_x;
    res_in.pixel_y      = s4_y;
    res_in.intensity    = s4_inr ? tbl_rdata : 8'd0;
    res_in.end_of_frame = s4_eof;
  end

  bmpl_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (adv && s4_push),
    .push_data (res_in),
    .in_ready  (adv),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res_out)
  );

  assign m_axis_tdata = {4'd0, res_out.intensity, res_out.pixel_y, res_out.pixel_x};
  assign m_axis_tlast = res_out.end_of_frame;

endmodule

`default_nettype wire

FILE: tb/sv/bump_map_phong_lighting_tb.sv
// ----------------------------------------------------------------------------
// bump_map_phong_lighting_tb
// Self-checking bench for the bump-mapped light spot renderer. The low corner
// of the spot table is loaded, and small spot sizes or a centered light keep
// every lookup in it; bordered height-map frames of many sizes, light
// positions and spot sizes then stream through. Every accepted item feeds a
// cycle-free predictor whose lit pixels are compared field by field with the
// block's output. The run mixes sender and receiver idling, forces one long
// output hold-off, and stops on a watchdog if the block goes quiet.
// ----------------------------------------------------------------------------
module bump_map_phong_lighting_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpl_pkg::*;

  localparam int LINE_LEN       = MAX_WIDTH_DEF + 2;
  localparam int SPOT_ENTRIES   = MAX_SPOT_SIZE_DEF * MAX_SPOT_SIZE_DEF;
  localparam int LOAD_ENTRIES   = 256;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 250;
  localparam int MAX_REPORTS    = 40;

  // Predictor of the lighting pipeline plus the queue of lit pixels due
  class lighting_scoreboard;
    bit [7:0]   spot_lut [SPOT_ENTRIES];
    bit [7:0]   top_row [LINE_LEN];
    bit [7:0]   mid_row [LINE_LEN];
    int         col, row;
    bit [7:0]   left_s, centre_s;
    logic [10:0] width_reg, height_reg;
    logic [9:0]  light_x, light_y;
    logic [8:0]  spot_reg;
    result_t    lit_pixels_due [$];
    int         errors, checked;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      light_x    = LIGHT_X_RST;
      light_y    = LIGHT_Y_RST;
      spot_reg   = SPOT_SIZE_RST;
      col = 0;
      row = 0;
      left_s = 0;
      centre_s = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return lit_pixels_due.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [10:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg = data;
        CFG_FRAME_HEIGHT: height_reg = data;
        CFG_LIGHT_X:      light_x = data[9:0];
        CFG_LIGHT_Y:      light_y = data[9:0];
        CFG_SPOT_SIZE:    spot_reg = data[8:0];
        default: ;
      endcase
    endfunction

    // One accepted item: table write, or height sample that may light a pixel
    function void shade_item(logic op, logic sof, logic [15:0] tbl_idx,
                             logic [7:0] tbl_val, logic [7:0] hgt);
      int w, h, res, c, r, xq, yq, half;
      bit [7:0] up, right, lit;
      result_t px;
      if (op == OP_TABLE_WRITE) begin
        spot_lut[tbl_idx] = tbl_val;
        return;
      end
      // out-of-range sizes saturate
      w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      res = (spot_reg < 2) ? 2 : (spot_reg > MAX_SPOT_SIZE_DEF) ? MAX_SPOT_SIZE_DEF : spot_reg;
      if (sof) begin
        col = 0;
        row = 0;
      end
      c = col;
      r = row;
      if (c < LINE_LEN) begin
        left_s = centre_s;
        centre_s = mid_row[c];
        up = top_row[c];
        if (r >= 2 && r <= h + 1 && c >= 1 && c <= w) begin
          half = res / 2;
          right = (c + 1 < LINE_LEN) ? mid_row[c + 1] : 8'd0;
          xq = int'(left_s) - int'(right) + (c - 1) - int'(light_x) + half;
          yq = int'(up) - int'(hgt) + (r - 2) - int'(light_y) + half;
          lit = 8'd0;
          // transposed lookup: column offset selects the table row
          if (xq >= 0 && yq >= 0 && xq < res && yq < res)
            lit = spot_lut[xq * res + yq];
          px.pixel_x = 10'(c - 1);
          px.pixel_y = 10'(r - 2);
          px.intensity = lit;
          px.end_of_frame = (c == w && r == h + 1);
          lit_pixels_due.push_back(px);
        end
        top_row[c] = centre_s;
        mid_row[c] = hgt;
      end
      // advance the bordered raster position
      if (c >= w + 1) begin
        col = 0;
        row = (r >= h + 1) ? 0 : ((r + 1) & 'h7FF);
      end else begin
        col = (c + 1) & 'h7FF;
      end
    endfunction

    task report(string msg);
      errors++;
      // keep the log short on a badly broken build
      if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task check_pixel(result_t got);
      result_t want;
      checked++;
      if (lit_pixels_due.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y));
        return;
      end
      want = lit_pixels_due.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report($sformatf("pixel_x got %0d expected %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report($sformatf("pixel_y got %0d expected %0d", got.pixel_y, want.pixel_y));
      if (got.intensity !== want.intensity)
        report($sformatf("intensity at (%0d,%0d) got %0d expected %0d", want.pixel_x,
                         want.pixel_y, got.intensity, want.intensity));
      if (got.end_of_frame !== want.end_of_frame)
        report($sformatf("end_of_frame at (%0d,%0d) got %0b expected %0b", want.pixel_x,
                         want.pixel_y, got.end_of_frame, want.end_of_frame));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [10:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // table_index[15:0], table_value[23:16], height_value[31:24]
  logic [1:0]  s_axis_tuser;   // operation[0], start_of_frame[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // pixel_x[9:0], pixel_y[19:10], intensity[27:20], pad[31:28]
  logic        m_axis_tlast;   // end_of_frame

  lighting_scoreboard sb;
  int idle_pct, stall_pct;
  bit hold_req;
  bit at_origin;
  int items_sent;

  bump_map_phong_lighting u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitors: output first, then register writes, then input items
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_pixel({m_axis_tlast, m_axis_tdata[27:0]});
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.shade_item(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[15:0],
                      s_axis_tdata[23:16], s_axis_tdata[31:24]);
    end
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", quiet);
    $display("status: fail");
    $finish;
  end

  // Offer one item after a random gap; returns on the accepting edge
  task automatic send_item(input logic op, input logic sof, input logic [15:0] idx,
                           input logic [7:0] val, input logic [7:0] hgt);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {sof, op};
    s_axis_tdata  <= {hgt, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Wait until every pixel due has come out and the pipeline has emptied
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned fw, input int unsigned fh,
                            input int unsigned lx, input int unsigned ly,
                            input int unsigned ss);
    cfg_reg_t    regs [5] = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_LIGHT_X,
                              CFG_LIGHT_Y, CFG_SPOT_SIZE};
    logic [10:0] vals [5];
    int k;
    vals = '{11'(fw), 11'(fh), 11'(lx), 11'(ly), 11'(ss)};
    drain();
    for (k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // One bordered frame; sometimes cut short, with stray table writes mixed in
  task automatic run_frame(input int w, input int h);
    int total, stop, n, shape;
    logic [7:0] base, hv;
    total = (w + 2) * (h + 2);
    stop  = ($urandom_range(99) < 12) ? $urandom_range(1, total - 1) : total;
    shape = $urandom_range(9);
    base  = 8'($urandom_range(0, 252));
    for (n = 0; n < stop; n++) begin
      if ($urandom_range(99) < 4)
        send_item(OP_TABLE_WRITE, 1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      if (shape < 6)
        hv = base + 8'($urandom_range(0, 3));
      else if (shape < 8)
        hv = 8'($urandom);
      else
        hv = base;
      // a frame may run on from the origin without the start flag
      send_item(OP_HEIGHT, (n == 0) && (!at_origin || $urandom_range(3) != 0),
                16'($urandom), 8'($urandom), hv);
    end
    at_origin = (stop == total);
  endtask

  task automatic run_segment(input int unsigned fw, input int unsigned fh,
                             input int unsigned lx, input int unsigned ly,
                             input int unsigned ss, input int nframes);
    int w, h, f;
    set_config(fw, fh, lx, ly, ss);
    w = (fw == 0) ? 1 : (fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : fw;
    h = (fh == 0) ? 1 : (fh > MAX_HEIGHT) ? MAX_HEIGHT : fh;
    for (f = 0; f < nframes; f++) run_frame(w, h);
  endtask

  initial begin : stimulus
    logic [7:0] steep [9] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    int k, p, goal, pick, rr;
    int unsigned fw, fh, lx, ly, ss;
    logic [7:0] lo_h, hi_h;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    at_origin = 1'b1;
    items_sent = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // load the table corner that spot sizes up to 16 can reach
    for (k = 0; k < LOAD_ENTRIES; k++)
      send_item(OP_TABLE_WRITE, 1'b0, 16'(k), 8'($urandom), 8'($urandom));

    // 1x1 frame, smallest spot, light at the origin: flat map lands in the spot
    set_config(1, 1, 0, 0, 2);
    for (k = 0; k < 9; k++)
      send_item(OP_HEIGHT, k == 0, 16'h0000, 8'h00, 8'h00);
    // overrun into a second frame with no start flag; steepest gradients fall
    // outside the spot; a table write carrying the start flag leaves the raster
    for (k = 0; k < 9; k++) begin
      if (k == 4) send_item(OP_TABLE_WRITE, 1'b1, 16'hFFFF, 8'hFF, 8'hFF);
      send_item(OP_HEIGHT, 1'b0, 16'hFFFF, 8'hFF, steep[k]);
    end
    // stop mid-row, then shrink the frame: stranded position emits nothing, wraps
    set_config(3, 2, 1, 0, 8);
    for (k = 0; k < 14; k++)
      send_item(OP_HEIGHT, k == 0, 16'h0000, 8'h00, 8'($urandom_range(0, 3)));
    set_config(1, 1, 0, 0, 8);
    for (k = 0; k < 10; k++)
      send_item(OP_HEIGHT, 1'b0, 16'h0000, 8'h00, 8'($urandom_range(0, 3)));

    // spot size above the limit saturates; one column with the light centered
    // keeps every lookup in the first table row or outside the spot
    set_config(1, 4, 128, $urandom_range(0, 4), 511);
    for (rr = 0; rr < 6; rr++) begin
      lo_h = 8'($urandom_range(0, 200));
      hi_h = ($urandom_range(2) == 0) ? lo_h : lo_h + 8'($urandom_range(1, 55));
      send_item(OP_HEIGHT, rr == 0, 16'h0000, 8'h00, lo_h);
      send_item(OP_HEIGHT, 1'b0, 16'h0000, 8'h00, 8'($urandom));
      send_item(OP_HEIGHT, 1'b0, 16'h0000, 8'h00, hi_h);
    end

    // random frames under four idling mixes
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      // long output hold-off while frames keep coming
      if (p == 0) hold_req = 1'b1;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        pick = $urandom_range(99);
        fw = (pick < 5) ? 0 : (pick < 12) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        fh = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 6);
        pick = $urandom_range(99);
        ss = (pick < 5) ? $urandom_range(0, 1) : $urandom_range(2, 16);
        lx = ($urandom_range(99) < 80) ? $urandom_range(0, (fw == 0) ? 1 : fw) :
             $urandom_range(0, 1023);
        ly = ($urandom_range(99) < 80) ? $urandom_range(0, (fh == 0) ? 1 : fh) :
             $urandom_range(0, 1023);
        run_segment(fw, fh, lx, ly, ss, $urandom_range(1, 2));
      end
    end

    drain();
    $display("run: %0d items sent, frames up to 20 wide, zero sizes, saturated spot, cut frames",
             items_sent);
    $display("run: %0d pixels checked across idling mixes and a long hold-off, %0d errors",
             sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
